[src/tnt_pkg.sv]
// Shared types and codes for the task notification table.
package tnt_pkg;

   // Request field widths
   localparam int MODE_BITS    = 3;
   localparam int TASK_BITS    = 4;
   localparam int ACTION_BITS  = 3;
   localparam int OPERAND_BITS = 32;
   localparam int RESULT_BITS  = 32;

   // Packed stream widths
   localparam int REQ_DATA_BITS = 48;
   localparam int RSP_DATA_BITS = 40;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Request modes
   localparam logic [MODE_BITS-1:0] MODE_NOTIFY    = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_TAKE_IN   = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_TAKE_OUT  = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_WAIT_IN   = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_WAIT_OUT  = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_CLEAR     = 3'd5;

   // Notify actions
   localparam logic [ACTION_BITS-1:0] ACT_NONE      = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_SET_BITS  = 3'd1;
   localparam logic [ACTION_BITS-1:0] ACT_INCREMENT = 3'd2;
   localparam logic [ACTION_BITS-1:0] ACT_OVERWRITE = 3'd3;
   localparam logic [ACTION_BITS-1:0] ACT_WRITE_NEW = 3'd4;

   // Per-entry notification state
   localparam logic [1:0] NST_IDLE = 2'd0;
   localparam logic [1:0] NST_WAIT = 2'd1;
   localparam logic [1:0] NST_NOTE = 2'd2;

   // Classified operation handed to the back end
   typedef enum logic [2:0] {
      OP_NOP      = 3'd0,
      OP_NOTIFY   = 3'd1,
      OP_TAKE_IN  = 3'd2,
      OP_TAKE_OUT = 3'd3,
      OP_WAIT_IN  = 3'd4,
      OP_WAIT_OUT = 3'd5,
      OP_CLEAR    = 3'd6
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [TASK_BITS-1:0]     task_idx;
      logic [ACTION_BITS-1:0]   action;
      logic [OPERAND_BITS-1:0]  operand;
      logic                     clear_all;
      logic                     may_block;
   } cmd_type;

   typedef struct packed {
      logic                    would_block;
      logic                    woken;
      logic [RESULT_BITS-1:0]  value_out;
      logic                    ok;
   } result_type;

endpackage

[src/tnt_front.sv]
// Request front end: unpacks and classifies items for the command queue.
module tnt_front #(
   parameter int TASK_COUNT = 16
) (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tnt_pkg::MODE_BITS-1:0]     req_tuser,
   input  logic [tnt_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                              push_valid,
   input  logic                              push_ready,
   output tnt_pkg::cmd_type                  push_cmd
);
   import tnt_pkg::*;

   logic [TASK_BITS-1:0] task_idx;
   logic [8:0]           task_wide;
   logic                 in_range;
   op_type               op;

   // Unpack the fields
   assign task_idx  = req_tdata[3:0];
   assign task_wide = 9'(task_idx);
   assign in_range  = task_wide < 9'(TASK_COUNT);

   // Decode mode; unused modes and absent tasks turn into a no-op
   always_comb begin
      unique case (req_tuser)
         MODE_NOTIFY:   op = OP_NOTIFY;
         MODE_TAKE_IN:  op = OP_TAKE_IN;
         MODE_TAKE_OUT: op = OP_TAKE_OUT;
         MODE_WAIT_IN:  op = OP_WAIT_IN;
         MODE_WAIT_OUT: op = OP_WAIT_OUT;
         MODE_CLEAR:    op = OP_CLEAR;
         default:       op = OP_NOP;
      endcase
      if (!in_range) begin
         op = OP_NOP;
      end
   end

   assign push_cmd.op        = op;
   assign push_cmd.task_idx  = task_idx;
   assign push_cmd.action    = req_tdata[6:4];
   assign push_cmd.operand   = req_tdata[38:7];
   assign push_cmd.clear_all = req_tdata[39];
   assign push_cmd.may_block = req_tdata[40];

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

[src/tnt_queue.sv]
// Short command queue that decouples the front end from the back end.
module tnt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  tnt_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output tnt_pkg::cmd_type pop_cmd
);
   import tnt_pkg::*;

   cmd_type                slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = count_ff != QCNT_BITS'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and the fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[src/tnt_back.sv]
// Back end: read-modify-write of one table entry per item and the result register.
module tnt_back #(
   parameter int TASK_COUNT = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  tnt_pkg::cmd_type                  cmd,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tnt_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import tnt_pkg::*;

   localparam int IDX_BITS   = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
   localparam int ENTRY_BITS = VALUE_BITS + 2;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   cmd_type                 cmd_ff;

   // Table storage: state in the top two bits, value below
   logic [ENTRY_BITS-1:0]   mem [TASK_COUNT];
   logic [TASK_COUNT-1:0]   vld_ff;
   logic [ENTRY_BITS-1:0]   rd_data_ff;
   logic                    rd_vld_ff;

   logic [8:0]              idx_wide;
   logic [IDX_BITS-1:0]     rd_addr;
   logic [IDX_BITS-1:0]     wr_addr;
   logic                    rd_en;
   logic                    wr_en;
   logic                    slot_free;

   logic [VALUE_BITS-1:0]   cur_val;
   logic [1:0]              cur_st;
   logic [VALUE_BITS-1:0]   opnd;
   logic [VALUE_BITS-1:0]   new_val;
   logic [1:0]              new_st;
   logic [VALUE_BITS-1:0]   ret_val;
   result_type              res;

   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_data_ff;

   assign idx_wide  = 9'(cmd.task_idx);
   assign rd_addr   = idx_wide[IDX_BITS-1:0];
   assign wr_addr   = 9'(cmd_ff.task_idx) > 9'd0 ? IDX_BITS'(cmd_ff.task_idx) : '0;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign cmd_ready = state_ff == S_IDLE;
   assign rd_en     = cmd_valid && cmd_ready && (cmd.op != OP_NOP);
   assign wr_en     = (state_ff == S_EXEC) && slot_free && (cmd_ff.op != OP_NOP);

   // Sequence: take an item and read its entry, then update and report
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold the command under execution
   always_ff @(posedge clock) begin
      if (cmd_valid && cmd_ready) begin
         cmd_ff <= cmd;
      end
   end

   // Table read and write ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {new_st, new_val};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Entry valid bits; an entry never written reads as zero and not waiting
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   // Carry out the operation on the fetched entry
   always_comb begin
      cur_val = rd_vld_ff ? rd_data_ff[VALUE_BITS-1:0] : '0;
      cur_st  = rd_vld_ff ? rd_data_ff[ENTRY_BITS-1:VALUE_BITS] : NST_IDLE;
      opnd    = VALUE_BITS'(cmd_ff.operand);
      new_val = cur_val;
      new_st  = cur_st;
      ret_val = '0;
      res     = '0;
      unique case (cmd_ff.op)
         OP_NOTIFY: begin
            ret_val   = cur_val;
            res.ok    = 1'b1;
            res.woken = cur_st == NST_WAIT;
            case (cmd_ff.action)
               ACT_SET_BITS:  new_val = cur_val | opnd;
               ACT_INCREMENT: new_val = cur_val + 1'b1;
               ACT_OVERWRITE: new_val = opnd;
               ACT_WRITE_NEW: begin
                  if (cur_st != NST_NOTE) begin
                     new_val = opnd;
                  end else begin
                     res.ok = 1'b0;
                  end
               end
               default: new_val = cur_val;
            endcase
            new_st = NST_NOTE;
         end
         OP_TAKE_IN: begin
            if (cur_val == '0) begin
               new_st          = NST_WAIT;
               res.would_block = cmd_ff.may_block;
            end else begin
               res.ok = 1'b1;
            end
            ret_val = cur_val;
         end
         OP_TAKE_OUT: begin
            ret_val = cur_val;
            if (cur_val != '0) begin
               res.ok  = 1'b1;
               new_val = cmd_ff.clear_all ? '0 : cur_val - 1'b1;
            end
            new_st = NST_IDLE;
         end
         OP_WAIT_IN: begin
            if (cur_st != NST_NOTE) begin
               new_val         = cur_val & ~opnd;
               new_st          = NST_WAIT;
               res.would_block = cmd_ff.may_block;
            end else begin
               res.ok = 1'b1;
            end
            ret_val = new_val;
         end
         OP_WAIT_OUT: begin
            ret_val = cur_val;
            if (cur_st != NST_WAIT) begin
               new_val = cur_val & ~opnd;
               res.ok  = 1'b1;
            end
            new_st = NST_IDLE;
         end
         OP_CLEAR: begin
            if (cur_st == NST_NOTE) begin
               new_st = NST_IDLE;
               res.ok = 1'b1;
            end
         end
         default: begin
            ret_val = '0;
         end
      endcase
      res.value_out = RESULT_BITS'(ret_val);
   end

   // Result register: load on completion, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == S_EXEC) && slot_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_EXEC) && slot_free) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_data_ff);

endmodule

[src/task_notification_table.sv]
// Top level of the task notification table.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_tvalid/tready    | tuser mode; tdata task, action, operand, flags
//   rsp     | out | rsp_tvalid/tready    | tdata ok, value_out, woken, would_block
//
// In the back end each item first has its table entry read into
// a register, then the entry is updated and the result register loaded; the back
// end takes no new item until the update is done, which is set by the registered
// table read and the write-back that follows it.
// A two-entry command queue lets requests keep arriving while a result stalls.
// Reset is synchronous and clears the entry valid bits at once: no clearing pass.
// A stalled result holds the back end; the queue then fills and drops req_tready.
module task_notification_table #(
   parameter int TASK_COUNT = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // mode[2:0]
   input  logic [tnt_pkg::MODE_BITS-1:0]     req_tuser,
   // task_req[3:0], action[6:4], operand[38:7], clear_all[39], may_block[40], zeros
   input  logic [tnt_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // ok[0], value_out[32:1], woken[33], would_block[34], zeros
   output logic [tnt_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import tnt_pkg::*;

   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_cmd;

   // Classify incoming items
   tnt_front #(
      .TASK_COUNT (TASK_COUNT)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // Buffer classified items
   tnt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // Execute against the table
   tnt_back #(
      .TASK_COUNT (TASK_COUNT),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (pop_valid),
      .cmd_ready  (pop_ready),
      .cmd        (pop_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[sim/tnt_result_checker.sv]
// Result checker for the task notification table: shadow table, prediction and compare.
module tnt_result_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   // mode[2:0]
   input  logic [tnt_pkg::MODE_BITS-1:0]     req_tuser,
   // task_req[3:0], action[6:4], operand[38:7], clear_all[39], may_block[40], zeros
   input  logic [tnt_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // ok[0], value_out[32:1], woken[33], would_block[34], zeros
   input  logic [tnt_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output int                                mismatch_count,
   output int                                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import tnt_pkg::*;

   localparam int TASK_SLOTS = 16;

   // Shadow copy of the notification table
   logic [RESULT_BITS-1:0] shadow_value [TASK_SLOTS];
   logic [1:0]             shadow_state [TASK_SLOTS];

   // Results owed by the block, oldest first
   result_type owed_results [$];

   // Apply one request to the shadow table and return the result it owes
   function automatic result_type apply_table_op(
      input logic [MODE_BITS-1:0]    mode,
      input logic [TASK_BITS-1:0]    idx,
      input logic [ACTION_BITS-1:0]  act,
      input logic [OPERAND_BITS-1:0] mask,
      input logic                    clr,
      input logic                    blk
   );
      result_type             res;
      logic [RESULT_BITS-1:0] val;
      logic [1:0]             st;
      res = '0;
      // unused modes and missing entries leave everything alone
      if (mode > MODE_CLEAR || int'(idx) >= TASK_SLOTS)
         return res;
      val = shadow_value[idx];
      st  = shadow_state[idx];
      case (mode)
         MODE_NOTIFY: begin
            res.value_out = val;
            res.ok        = 1'b1;
            res.woken     = (st == NST_WAIT);
            case (act)
               ACT_SET_BITS:  val = val | mask;
               ACT_INCREMENT: val = val + 1'b1;
               ACT_OVERWRITE: val = mask;
               ACT_WRITE_NEW: begin
                  if (st != NST_NOTE)
                     val = mask;
                  else
                     res.ok = 1'b0;
               end
               default: ;
            endcase
            st = NST_NOTE;
         end
         MODE_TAKE_IN: begin
            if (val == '0) begin
               st              = NST_WAIT;
               res.would_block = blk;
            end else begin
               res.ok = 1'b1;
            end
            res.value_out = val;
         end
         MODE_TAKE_OUT: begin
            res.value_out = val;
            if (val != '0) begin
               res.ok = 1'b1;
               val    = clr ? '0 : val - 1'b1;
            end
            st = NST_IDLE;
         end
         MODE_WAIT_IN: begin
            if (st != NST_NOTE) begin
               val             = val & ~mask;
               st              = NST_WAIT;
               res.would_block = blk;
            end else begin
               res.ok = 1'b1;
            end
            res.value_out = val;
         end
         MODE_WAIT_OUT: begin
            res.value_out = val;
            if (st != NST_WAIT) begin
               val    = val & ~mask;
               res.ok = 1'b1;
            end
            st = NST_IDLE;
         end
         default: begin
            if (st == NST_NOTE) begin
               st     = NST_IDLE;
               res.ok = 1'b1;
            end
         end
      endcase
      shadow_value[idx] = val;
      shadow_state[idx] = st;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [RESULT_BITS-1:0] want,
                              input logic [RESULT_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Compare results leaving the block, then predict for items entering it
   always @(posedge clock) begin : watch
      result_type got;
      result_type want;
      if (reset) begin
         foreach (shadow_value[i]) begin
            shadow_value[i] = '0;
            shadow_state[i] = NST_IDLE;
         end
         owed_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
            if (owed_results.size() == 0) begin
               $display("%0t ns: result with none expected, expected none actual %h",
                        $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = owed_results.pop_front();
               check_field("ok", RESULT_BITS'(want.ok), RESULT_BITS'(got.ok));
               check_field("value_out", want.value_out, got.value_out);
               check_field("woken", RESULT_BITS'(want.woken), RESULT_BITS'(got.woken));
               check_field("would_block", RESULT_BITS'(want.would_block),
                           RESULT_BITS'(got.would_block));
            end
         end
         if (req_tvalid && req_tready)
            owed_results.push_back(apply_table_op(req_tuser, req_tdata[3:0], req_tdata[6:4],
                                                  req_tdata[38:7], req_tdata[39],
                                                  req_tdata[40]));
      end
      outstanding <= owed_results.size();
   end

endmodule

[sim/tb_task_notification_table.sv]
// Testbench top for the task notification table: stimulus, handshake pacing and verdict.
module tb_task_notification_table;
   timeunit 1ns;
   timeprecision 1ps;
   import tnt_pkg::*;

   // Codes the block leaves unused
   localparam logic [MODE_BITS-1:0]   MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_BITS-1:0]   MODE_SPARE_HI = 3'd7;
   localparam logic [ACTION_BITS-1:0] ACT_SPARE_LO  = 3'd5;
   localparam logic [ACTION_BITS-1:0] ACT_SPARE_HI  = 3'd7;

   localparam int CYCLE_LIMIT  = 200_000;
   localparam int DRAIN_CYCLES = 16;

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // mode[2:0]
   logic [MODE_BITS-1:0]     req_tuser  = '0;
   // task_req[3:0], action[6:4], operand[38:7], clear_all[39], may_block[40], zeros
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // ok[0], value_out[32:1], woken[33], would_block[34], zeros
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   int mismatch_count;
   int outstanding;
   int cycle_count   = 0;
   int item_count    = 0;
   int send_idle_pct = 16;
   int rsp_idle_pct  = 68;

   task_notification_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   tnt_result_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tuser      (req_tuser),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Offer one item after a random gap and hold it until taken
   task automatic push_request(
      input logic [MODE_BITS-1:0]    mode,
      input logic [TASK_BITS-1:0]    idx,
      input logic [ACTION_BITS-1:0]  act,
      input logic [OPERAND_BITS-1:0] mask,
      input logic                    clr,
      input logic                    blk
   );
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {7'b0, blk, clr, mask, act, idx};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      item_count++;
   endtask

   // Mix of random words, small counts and all-ones
   function automatic logic [OPERAND_BITS-1:0] draw_operand();
      case ($urandom_range(3))
         0:       return $urandom_range(3);
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Mostly defined actions, now and then an unused code
   function automatic logic [ACTION_BITS-1:0] draw_action();
      if ($urandom_range(9) == 0)
         return ACTION_BITS'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
      return ACTION_BITS'($urandom_range(ACT_WRITE_NEW));
   endfunction

   // One random sequence on one entry, or a stray item
   task automatic run_scenario();
      logic [TASK_BITS-1:0] idx;
      int                   pick;
      idx  = TASK_BITS'($urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 12) begin
         // anything at all, unused modes included
         push_request(MODE_BITS'($urandom_range(MODE_SPARE_HI)), idx,
                      ACTION_BITS'($urandom_range(ACT_SPARE_HI)), draw_operand(),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (pick < 40) begin
         // take entry, maybe a notify, take exit
         if ($urandom_range(1))
            push_request(MODE_NOTIFY, idx, draw_action(), draw_operand(), 1'b0, 1'b0);
         push_request(MODE_TAKE_IN, idx, draw_action(), draw_operand(),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
         if ($urandom_range(1))
            push_request(MODE_NOTIFY, idx, draw_action(), draw_operand(),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
         push_request(MODE_TAKE_OUT, idx, draw_action(), draw_operand(),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (pick < 70) begin
         // wait entry, maybe a notify, wait exit
         if ($urandom_range(2) == 0)
            push_request(MODE_NOTIFY, idx, draw_action(), draw_operand(), 1'b0, 1'b0);
         push_request(MODE_WAIT_IN, idx, draw_action(), draw_operand(),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
         if ($urandom_range(1))
            push_request(MODE_NOTIFY, idx, draw_action(), draw_operand(),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
         push_request(MODE_WAIT_OUT, idx, draw_action(), draw_operand(),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (pick < 85) begin
         // notify then clear the state, sometimes twice
         push_request(MODE_NOTIFY, idx, draw_action(), draw_operand(), 1'b0, 1'b1);
         push_request(MODE_CLEAR, idx, draw_action(), draw_operand(),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
         if ($urandom_range(1))
            push_request(MODE_CLEAR, idx, draw_action(), draw_operand(), 1'b1, 1'b0);
      end else begin
         push_request(MODE_NOTIFY, idx, draw_action(), draw_operand(),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: notify actions and the conditional write
      push_request(MODE_NOTIFY, 4'd0, ACT_NONE, 32'h0, 1'b0, 1'b0);
      push_request(MODE_NOTIFY, 4'd0, ACT_WRITE_NEW, 32'hDEADBEEF, 1'b0, 1'b0);
      push_request(MODE_CLEAR, 4'd0, ACT_NONE, 32'h0, 1'b0, 1'b0);
      push_request(MODE_NOTIFY, 4'd0, ACT_WRITE_NEW, 32'hFFFFFFFF, 1'b1, 1'b1);
      push_request(MODE_NOTIFY, 4'd0, ACT_INCREMENT, 32'h0, 1'b0, 1'b0);
      // take: block on zero, wake, decrement, clear, exit on zero
      push_request(MODE_TAKE_IN, 4'd5, ACT_NONE, 32'h0, 1'b0, 1'b1);
      push_request(MODE_NOTIFY, 4'd5, ACT_SET_BITS, 32'h80000001, 1'b0, 1'b0);
      push_request(MODE_TAKE_OUT, 4'd5, ACT_NONE, 32'h0, 1'b0, 1'b0);
      push_request(MODE_TAKE_IN, 4'd5, ACT_NONE, 32'h0, 1'b0, 1'b1);
      push_request(MODE_TAKE_OUT, 4'd5, ACT_NONE, 32'h0, 1'b1, 1'b0);
      push_request(MODE_TAKE_OUT, 4'd5, ACT_NONE, 32'h0, 1'b0, 1'b0);
      push_request(MODE_TAKE_IN, 4'd9, ACT_NONE, 32'h0, 1'b0, 1'b0);
      // wait: exit while still waiting, then notified entry and exit mask
      push_request(MODE_WAIT_IN, 4'd10, ACT_NONE, 32'hFFFF0000, 1'b0, 1'b1);
      push_request(MODE_WAIT_OUT, 4'd10, ACT_NONE, 32'h0, 1'b0, 1'b0);
      push_request(MODE_NOTIFY, 4'd10, ACT_OVERWRITE, 32'hA5A5A5A5, 1'b0, 1'b0);
      push_request(MODE_WAIT_IN, 4'd10, ACT_NONE, 32'hFFFFFFFF, 1'b0, 1'b1);
      push_request(MODE_WAIT_OUT, 4'd10, ACT_NONE, 32'h0000FFFF, 1'b0, 1'b0);
      // unused actions act as none; clear twice; unused modes
      push_request(MODE_NOTIFY, 4'd15, ACT_SPARE_HI, 32'h12345678, 1'b0, 1'b0);
      push_request(MODE_NOTIFY, 4'd15, ACT_SPARE_LO, 32'h87654321, 1'b0, 1'b0);
      push_request(MODE_CLEAR, 4'd15, ACT_NONE, 32'h0, 1'b0, 1'b0);
      push_request(MODE_CLEAR, 4'd15, ACT_NONE, 32'h0, 1'b0, 1'b0);
      push_request(MODE_SPARE_LO, 4'd15, ACT_NONE, 32'h0, 1'b0, 1'b0);
      push_request(MODE_SPARE_HI, 4'd15, ACT_SPARE_HI, 32'hFFFFFFFF, 1'b1, 1'b1);
      push_request(MODE_NOTIFY, 4'd15, ACT_INCREMENT, 32'h0, 1'b0, 1'b0);

      // Random: slow receiver, then slow sender, then full rate
      while (item_count < 550)
         run_scenario();
      send_idle_pct = 68;
      rsp_idle_pct  = 16;
      while (item_count < 1100)
         run_scenario();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      while (item_count < 1650)
         run_scenario();
      req_tvalid <= 1'b0;

      // Drain the owed results, then let the pipeline settle
      do
         @(posedge clock);
      while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
